>>> src/brb_pkg.sv
package brb_pkg;

  localparam int unsigned CAPACITY  = 4096;
  localparam int unsigned MAX_BURST = 64;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned BURST_W = 7;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned OP_W    = 2;

  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(CAPACITY);
  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(CAPACITY);
  localparam logic [BURST_W-1:0] BURST_MAX = BURST_W'(MAX_BURST);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_NONE  = 2'd3
  } brb_op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } brb_state_e;

  // controller -> datapath
  typedef struct packed {
    logic do_write;
    logic start_burst;
    logic emit_empty;
    logic emit_byte;
  } brb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic grant_zero;
    logic last_byte;
  } brb_status_t;

endpackage

>>> src/byte_ring_buffer_with_peek.sv
// Timing: a write, empty read or unused op gives its result in the cycle after the
// request is taken; a read or peek enters the burst state, then reads each byte into
// the output register. Throughput: one request per cycle for writes, empty reads and
// unused ops while the output is free; a read or peek holds the input for a start
// step and one store read per byte (single read port), longer under output stalls.
// Reset: pointers and wrap flag cleared, ring length 4096; byte store not cleared.
module byte_ring_buffer_with_peek (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [brb_pkg::OP_W-1:0]      op_i,
  input  logic [brb_pkg::DATA_W-1:0]    data_in_i,
  input  logic [brb_pkg::BURST_W-1:0]   burst_length_i,
  input  logic                          cfg_we_i,
  input  logic [brb_pkg::LEN_W-1:0]     cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brb_pkg::DATA_W-1:0]    data_out_o,
  output logic                          byte_valid_o,
  output logic                          accepted_o,
  output logic                          last_o,
  output logic [brb_pkg::BURST_W-1:0]   granted_o,
  output logic [brb_pkg::LEN_W-1:0]     fill_level_o
);

  brb_pkg::brb_cmd_t    cmd;
  brb_pkg::brb_status_t status;

  brb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  brb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .data_in_i      (data_in_i),
    .burst_length_i (burst_length_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_o     (data_out_o),
    .byte_valid_o   (byte_valid_o),
    .accepted_o     (accepted_o),
    .last_o         (last_o),
    .granted_o      (granted_o),
    .fill_level_o   (fill_level_o)
  );

endmodule

>>> src/brb_ctrl.sv
module brb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [brb_pkg::OP_W-1:0] op_i,
  input  brb_pkg::brb_status_t status_i,
  output logic                 in_ready_o,
  output brb_pkg::brb_cmd_t    cmd_o
);

  brb_pkg::brb_state_e state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == brb_pkg::ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      brb_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_i)
            brb_pkg::OP_WRITE: begin
              cmd_o.do_write = 1'b1;
            end
            brb_pkg::OP_READ, brb_pkg::OP_PEEK: begin
              if (status_i.grant_zero) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                cmd_o.start_burst = 1'b1;
                state_d = brb_pkg::ST_BURST;
              end
            end
            default: begin
              cmd_o.emit_empty = 1'b1;
            end
          endcase
        end
      end
      brb_pkg::ST_BURST: begin
        if (status_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          if (status_i.last_byte) begin
            state_d = brb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = brb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/brb_dp.sv
module brb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brb_pkg::brb_cmd_t             cmd_i,
  output brb_pkg::brb_status_t          status_o,
  input  logic [brb_pkg::OP_W-1:0]      op_i,
  input  logic [brb_pkg::DATA_W-1:0]    data_in_i,
  input  logic [brb_pkg::BURST_W-1:0]   burst_length_i,
  input  logic                          cfg_we_i,
  input  logic [brb_pkg::LEN_W-1:0]     cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brb_pkg::DATA_W-1:0]    data_out_o,
  output logic                          byte_valid_o,
  output logic                          accepted_o,
  output logic                          last_o,
  output logic [brb_pkg::BURST_W-1:0]   granted_o,
  output logic [brb_pkg::LEN_W-1:0]     fill_level_o
);

  logic [brb_pkg::DATA_W-1:0] mem_q [brb_pkg::CAPACITY];

  logic [brb_pkg::ADDR_W-1:0]  rp_q, wp_q, cur_q;
  logic                        wf_q, cur_wf_q, peek_q;
  logic [brb_pkg::LEN_W-1:0]   len_q, fill_q;
  logic [brb_pkg::BURST_W-1:0] cnt_q, grant_q;

  logic                        out_valid_q, out_bv_q, out_acc_q, out_last_q;
  logic [brb_pkg::DATA_W-1:0]  out_data_q;
  logic [brb_pkg::BURST_W-1:0] out_grant_q;
  logic [brb_pkg::LEN_W-1:0]   out_fill_q;

  logic [brb_pkg::LEN_W-1:0]   held, cfg_len;
  logic                        can_write, wp_wrap, cur_wrap;
  logic [brb_pkg::LEN_W-1:0]   wp_inc, cur_inc;
  logic [brb_pkg::BURST_W-1:0] burst_clip, grant_n;
  logic [brb_pkg::LEN_W-1:0]   fill_next;
  logic                        load_out;

  assign held = wf_q ? (len_q - {1'b0, rp_q} + {1'b0, wp_q})
                     : ({1'b0, wp_q} - {1'b0, rp_q});

  assign can_write = (held != len_q);
  assign wp_inc    = {1'b0, wp_q} + brb_pkg::LEN_W'(1);
  assign wp_wrap   = (wp_inc >= len_q);
  assign cur_inc   = {1'b0, cur_q} + brb_pkg::LEN_W'(1);
  assign cur_wrap  = (cur_inc >= len_q);

  assign burst_clip = (burst_length_i > brb_pkg::BURST_MAX) ? brb_pkg::BURST_MAX
                                                            : burst_length_i;
  assign grant_n = ({6'd0, burst_clip} > held) ? held[brb_pkg::BURST_W-1:0] : burst_clip;

  assign fill_next = peek_q ? fill_q : (fill_q - brb_pkg::LEN_W'(1));

  // zero clamps to one, oversize clamps to capacity
  assign cfg_len = (cfg_wdata_i == '0) ? brb_pkg::LEN_W'(1)
                 : (cfg_wdata_i > brb_pkg::LEN_MAX) ? brb_pkg::LEN_MAX : cfg_wdata_i;

  assign load_out = cmd_i.do_write || cmd_i.emit_empty || cmd_i.emit_byte;

  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.grant_zero = (grant_n == '0);
  assign status_o.last_byte  = (cnt_q == brb_pkg::BURST_W'(1));

  // store write and burst read; read data lands in the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && can_write) begin
      mem_q[wp_q] <= data_in_i;
    end
    if (cmd_i.emit_byte) begin
      out_data_q <= mem_q[cur_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      wf_q        <= 1'b0;
      len_q       <= brb_pkg::LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_len;
        rp_q  <= '0;
        wp_q  <= '0;
        wf_q  <= 1'b0;
      end else if (cmd_i.do_write && can_write) begin
        if (wp_wrap) begin
          wp_q <= '0;
          wf_q <= !wf_q;
        end else begin
          wp_q <= wp_inc[brb_pkg::ADDR_W-1:0];
        end
      end else if (cmd_i.emit_byte && status_o.last_byte && !peek_q) begin
        rp_q <= cur_wrap ? '0 : cur_inc[brb_pkg::ADDR_W-1:0];
        wf_q <= cur_wrap ? !cur_wf_q : cur_wf_q;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // burst cursor and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_burst) begin
      cur_q    <= rp_q;
      cur_wf_q <= wf_q;
      fill_q   <= held;
      cnt_q    <= grant_n;
      grant_q  <= grant_n;
      peek_q   <= (op_i == brb_pkg::OP_PEEK);
    end else if (cmd_i.emit_byte) begin
      cur_q    <= cur_wrap ? '0 : cur_inc[brb_pkg::ADDR_W-1:0];
      cur_wf_q <= cur_wrap ? !cur_wf_q : cur_wf_q;
      fill_q   <= fill_next;
      cnt_q    <= cnt_q - brb_pkg::BURST_W'(1);
    end

    if (cmd_i.do_write) begin
      out_bv_q    <= 1'b0;
      out_acc_q   <= can_write;
      out_last_q  <= 1'b1;
      out_grant_q <= '0;
      out_fill_q  <= held + brb_pkg::LEN_W'(can_write);
    end else if (cmd_i.emit_empty) begin
      out_bv_q    <= 1'b0;
      out_acc_q   <= 1'b0;
      out_last_q  <= 1'b1;
      out_grant_q <= '0;
      out_fill_q  <= held;
    end else if (cmd_i.emit_byte) begin
      out_bv_q    <= 1'b1;
      out_acc_q   <= 1'b0;
      out_last_q  <= status_o.last_byte;
      out_grant_q <= grant_q;
      out_fill_q  <= fill_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_bv_q ? out_data_q : '0;
  assign byte_valid_o = out_bv_q;
  assign accepted_o   = out_acc_q;
  assign last_o       = out_last_q;
  assign granted_o    = out_grant_q;
  assign fill_level_o = out_fill_q;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned PHASE_REQS    = 18;
  localparam int unsigned FILL_RUN_MAX  = 12;
  localparam int unsigned DEEP_FILL     = 70;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_PRINTS    = 100;

  typedef struct packed {
    logic [brb_pkg::DATA_W-1:0]  data;
    logic                        byte_valid;
    logic                        accepted;
    logic                        last;
    logic [brb_pkg::BURST_W-1:0] granted;
    logic [brb_pkg::LEN_W-1:0]   fill_level;
  } ring_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [brb_pkg::LEN_W-1:0]   cfg_value;
    brb_pkg::brb_op_e            op;
    logic [brb_pkg::DATA_W-1:0]  data;
    logic [brb_pkg::BURST_W-1:0] burst;
    logic                        fixed;
    ring_result_t                want;
  } dir_row_t;

  localparam ring_result_t NO_RES   = '0;
  localparam ring_result_t EMPTY_0  = '{8'h00, 1'b0, 1'b0, 1'b1, 7'd0, 13'd0};
  localparam ring_result_t STORED_1 = '{8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 13'd1};
  localparam ring_result_t STORED_2 = '{8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 13'd2};
  localparam ring_result_t STORED_3 = '{8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 13'd3};
  localparam ring_result_t EMPTY_3  = '{8'h00, 1'b0, 1'b0, 1'b1, 7'd0, 13'd3};
  localparam ring_result_t DROP_1   = '{8'h00, 1'b0, 1'b0, 1'b1, 7'd0, 13'd1};
  localparam ring_result_t DROP_3   = '{8'h00, 1'b0, 1'b0, 1'b1, 7'd0, 13'd3};

  // Directed rows; rows with fixed = 1 carry a hand-written expectation.
  localparam dir_row_t DIR_TAB [28] = '{
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'h00, 7'd5,   1'b1, EMPTY_0},
    '{ROW_REQ, 13'd0, brb_pkg::OP_PEEK,  8'h00, 7'd127, 1'b1, EMPTY_0},
    '{ROW_REQ, 13'd0, brb_pkg::OP_NONE,  8'hFF, 7'd127, 1'b1, EMPTY_0},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h00, 7'd0,   1'b1, STORED_1},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'hFF, 7'd127, 1'b1, STORED_2},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h5A, 7'd0,   1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_PEEK,  8'h00, 7'd0,   1'b1, EMPTY_3},
    '{ROW_REQ, 13'd0, brb_pkg::OP_PEEK,  8'h00, 7'd127, 1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'h00, 7'd2,   1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'hFF, 7'd127, 1'b0, NO_RES},
    // length 0 behaves as a one-byte ring
    '{ROW_CFG, 13'd0, brb_pkg::OP_NONE,  8'h00, 7'd0,   1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'hC3, 7'd0,   1'b1, STORED_1},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h3C, 7'd0,   1'b1, DROP_1},
    '{ROW_REQ, 13'd0, brb_pkg::OP_PEEK,  8'h00, 7'd1,   1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'h00, 7'd64,  1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'h00, 7'd1,   1'b1, EMPTY_0},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h81, 7'd0,   1'b1, STORED_1},
    // oversize length clamps to capacity and empties the ring
    '{ROW_CFG, 13'd8191, brb_pkg::OP_NONE, 8'h00, 7'd0, 1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'h00, 7'd1,   1'b1, EMPTY_0},
    '{ROW_CFG, 13'd3, brb_pkg::OP_NONE,  8'h00, 7'd0,   1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h01, 7'd0,   1'b1, STORED_1},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h02, 7'd0,   1'b1, STORED_2},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h04, 7'd0,   1'b1, STORED_3},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h08, 7'd0,   1'b1, DROP_3},
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'h00, 7'd2,   1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_WRITE, 8'h10, 7'd0,   1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_PEEK,  8'h00, 7'd64,  1'b0, NO_RES},
    '{ROW_REQ, 13'd0, brb_pkg::OP_READ,  8'h00, 7'd127, 1'b0, NO_RES}
  };

  localparam logic [brb_pkg::LEN_W-1:0] PHASE_LENS [11] = '{
    13'd4096, 13'd1, 13'd2, 13'd5, 13'd64, 13'd65, 13'd100, 13'd0, 13'd8191, 13'd4095, 13'd37
  };

  logic                        clk = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  brb_pkg::brb_op_e            req_op = brb_pkg::OP_WRITE;
  logic [brb_pkg::DATA_W-1:0]  req_data = '0;
  logic [brb_pkg::BURST_W-1:0] req_burst = '0;
  logic                        cfg_we = 1'b0;
  logic [brb_pkg::LEN_W-1:0]   cfg_wdata = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic [brb_pkg::DATA_W-1:0]  rsp_data;
  logic                        rsp_byte_valid;
  logic                        rsp_accepted;
  logic                        rsp_last;
  logic [brb_pkg::BURST_W-1:0] rsp_granted;
  logic [brb_pkg::LEN_W-1:0]   rsp_fill;

  // predictor state
  logic [brb_pkg::DATA_W-1:0]  ring_store [brb_pkg::CAPACITY];
  logic [brb_pkg::ADDR_W-1:0]  rd_ptr;
  logic [brb_pkg::ADDR_W-1:0]  wr_ptr;
  logic                        wrapped;
  logic [brb_pkg::LEN_W-1:0]   ring_len;

  ring_result_t       due_results_q [$];
  int unsigned        err_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        tx_burst_left = 0;
  rx_mode_e           rx_mode = RX_ALWAYS;
  int unsigned        rx_hold = 0;
  int unsigned        rx_tick = 0;

  byte_ring_buffer_with_peek u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_valid),
    .in_ready_o     (req_ready),
    .op_i           (req_op),
    .data_in_i      (req_data),
    .burst_length_i (req_burst),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .out_valid_o    (rsp_valid),
    .out_ready_i    (rsp_ready),
    .data_out_o     (rsp_data),
    .byte_valid_o   (rsp_byte_valid),
    .accepted_o     (rsp_accepted),
    .last_o         (rsp_last),
    .granted_o      (rsp_granted),
    .fill_level_o   (rsp_fill)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [brb_pkg::LEN_W-1:0] held_count();
    if (wrapped) return ring_len - brb_pkg::LEN_W'(rd_ptr) + brb_pkg::LEN_W'(wr_ptr);
    return brb_pkg::LEN_W'(wr_ptr) - brb_pkg::LEN_W'(rd_ptr);
  endfunction

  function automatic void ring_set_length(input logic [brb_pkg::LEN_W-1:0] value);
    if (value == '0) ring_len = brb_pkg::LEN_W'(1);
    else if (value > brb_pkg::LEN_MAX) ring_len = brb_pkg::LEN_MAX;
    else ring_len = value;
    rd_ptr  = '0;
    wr_ptr  = '0;
    wrapped = 1'b0;
  endfunction

  // Results one request produces; advances the ring state as the block does.
  function automatic void ring_predict_request(input brb_pkg::brb_op_e op,
                                               input logic [brb_pkg::DATA_W-1:0] data,
                                               input logic [brb_pkg::BURST_W-1:0] burst,
                                               ref ring_result_t res[$]);
    ring_result_t               r;
    logic [brb_pkg::LEN_W-1:0]  avail;
    logic [brb_pkg::LEN_W-1:0]  fill;
    logic [brb_pkg::LEN_W-1:0]  n;
    logic [brb_pkg::LEN_W-1:0]  nxt;
    logic [brb_pkg::ADDR_W-1:0] rp;
    logic                       wf;
    int                         i;
    r = '0;
    r.last = 1'b1;
    case (op)
      brb_pkg::OP_WRITE: begin
        if (ring_len != held_count()) begin
          ring_store[wr_ptr] = data;
          nxt = brb_pkg::LEN_W'(wr_ptr) + brb_pkg::LEN_W'(1);
          if (nxt >= ring_len) begin
            wr_ptr  = '0;
            wrapped = ~wrapped;
          end else begin
            wr_ptr = nxt[brb_pkg::ADDR_W-1:0];
          end
          r.accepted = 1'b1;
        end
        r.fill_level = held_count();
        res.push_back(r);
      end
      brb_pkg::OP_READ, brb_pkg::OP_PEEK: begin
        avail = held_count();
        n = brb_pkg::LEN_W'(burst);
        if (n > brb_pkg::LEN_W'(brb_pkg::BURST_MAX)) n = brb_pkg::LEN_W'(brb_pkg::BURST_MAX);
        if (n > avail) n = avail;
        if (n == '0) begin
          r.fill_level = avail;
          res.push_back(r);
        end else begin
          rp   = rd_ptr;
          wf   = wrapped;
          fill = avail;
          for (i = 0; i < int'(n); i++) begin
            r.data       = ring_store[rp];
            r.byte_valid = 1'b1;
            r.granted    = brb_pkg::BURST_W'(n);
            r.last       = (i + 1 == int'(n));
            nxt = brb_pkg::LEN_W'(rp) + brb_pkg::LEN_W'(1);
            if (nxt >= ring_len) begin
              rp = '0;
              wf = ~wf;
            end else begin
              rp = nxt[brb_pkg::ADDR_W-1:0];
            end
            if (op == brb_pkg::OP_READ) fill = fill - brb_pkg::LEN_W'(1);
            r.fill_level = fill;
            res.push_back(r);
          end
          if (op == brb_pkg::OP_READ) begin
            rd_ptr  = rp;
            wrapped = wf;
          end
        end
      end
      default: begin
        r.fill_level = held_count();
        res.push_back(r);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [brb_pkg::LEN_W-1:0] got,
                             input logic [brb_pkg::LEN_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Called on a falling edge; returns on the falling edge after acceptance.
  task automatic send_req(input brb_pkg::brb_op_e op,
                          input logic [brb_pkg::DATA_W-1:0] data,
                          input logic [brb_pkg::BURST_W-1:0] burst, input logic fixed,
                          input ring_result_t fixed_res);
    ring_result_t res_q [$];
    int unsigned  gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    tx_burst_left--;
    req_valid <= 1'b1;
    req_op    <= op;
    req_data  <= data;
    req_burst <= burst;
    do @(posedge clk); while (!req_ready);
    ring_predict_request(op, data, burst, res_q);
    if (fixed) due_results_q.push_back(fixed_res);
    else foreach (res_q[k]) due_results_q.push_back(res_q[k]);
    @(negedge clk);
  endtask

  // Hold off new requests until every expected result has come out.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(negedge clk);
    while (due_results_q.size() != 0) @(negedge clk);
    tx_burst_left = 0;
  endtask

  task automatic write_length(input logic [brb_pkg::LEN_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    ring_set_length(value);
  endtask

  always @(negedge clk) begin
    rx_tick++;
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_hold = $urandom_range(50, 200);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_ALWAYS: rsp_ready <= 1'b1;
      RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
      default:   rsp_ready <= ((rx_tick % 5) < 2);
    endcase
  end

  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_ni && rsp_valid && rsp_ready) begin
      if (due_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, data %0h fill %0d", rsp_data, rsp_fill));
      end else begin
        want = due_results_q.pop_front();
        check_field("data_out", brb_pkg::LEN_W'(rsp_data), brb_pkg::LEN_W'(want.data));
        check_field("byte_valid", brb_pkg::LEN_W'(rsp_byte_valid),
                    brb_pkg::LEN_W'(want.byte_valid));
        check_field("accepted", brb_pkg::LEN_W'(rsp_accepted), brb_pkg::LEN_W'(want.accepted));
        check_field("last", brb_pkg::LEN_W'(rsp_last), brb_pkg::LEN_W'(want.last));
        check_field("granted", brb_pkg::LEN_W'(rsp_granted), brb_pkg::LEN_W'(want.granted));
        check_field("fill_level", rsp_fill, want.fill_level);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned                 reqs;
    int unsigned                 pick;
    int unsigned                 run_len;
    logic [brb_pkg::BURST_W-1:0] bl;
    ring_set_length(brb_pkg::LEN_RESET);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) write_length(DIR_TAB[i].cfg_value);
      else send_req(DIR_TAB[i].op, DIR_TAB[i].data, DIR_TAB[i].burst,
                    DIR_TAB[i].fixed, DIR_TAB[i].want);
    end

    foreach (PHASE_LENS[p]) begin
      write_length(PHASE_LENS[p]);
      if (p == 0) begin
        // enough bytes held for a request to be clipped at the burst limit
        repeat (DEEP_FILL)
          send_req(brb_pkg::OP_WRITE, brb_pkg::DATA_W'($urandom),
                   brb_pkg::BURST_W'($urandom), 1'b0, NO_RES);
        send_req(brb_pkg::OP_PEEK, brb_pkg::DATA_W'($urandom), 7'd127, 1'b0, NO_RES);
        send_req(brb_pkg::OP_READ, brb_pkg::DATA_W'($urandom), 7'd100, 1'b0, NO_RES);
      end
      reqs = 0;
      while (reqs < PHASE_REQS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          run_len = $urandom_range(1, FILL_RUN_MAX);
          repeat (run_len)
            send_req(brb_pkg::OP_WRITE, brb_pkg::DATA_W'($urandom),
                     brb_pkg::BURST_W'($urandom), 1'b0, NO_RES);
          reqs += run_len;
        end else if (pick < 92) begin
          bl = ($urandom_range(0, 3) == 0) ? brb_pkg::BURST_W'($urandom_range(0, 127))
                                           : brb_pkg::BURST_W'($urandom_range(0, 8));
          send_req((pick < 70) ? brb_pkg::OP_READ : brb_pkg::OP_PEEK,
                   brb_pkg::DATA_W'($urandom), bl, 1'b0, NO_RES);
          reqs++;
        end else if (pick < 97) begin
          send_req(brb_pkg::OP_NONE, brb_pkg::DATA_W'($urandom),
                   brb_pkg::BURST_W'($urandom), 1'b0, NO_RES);
        end else begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (err_count == 0 && due_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
